// File: design/tmdm_pkg.sv
// Package for the trimmed-mean batch averager.
// Sample and register widths, register map, and shared-unit op codes.
// No dependencies.
package tmdm_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int CFG_W     = 5;
  localparam int CFG_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int MIN_BATCH = 3;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
  localparam logic [CFG_W-1:0]    CFG_RESET  = CFG_W'(10);

  // register map (byte addresses)
  localparam logic [CFG_AW-1:0] ADDR_SAMPLE_COUNT = CFG_AW'(0);

  typedef logic [SAMPLE_W-1:0] sample_t;

  // operations of the shared add/subtract unit
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

// File: design/tmdm_if.sv
// Valid/ready channel interfaces for the trimmed-mean batch averager.
// Depends on tmdm_pkg for the payload types.
interface tmdm_in_if;
  import tmdm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tmdm_out_if;
  import tmdm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

// File: design/trimmed_mean_drop_min_max_core.sv
// Trimmed-mean batch averager: drops one minimum and one maximum per batch.
// Depends on tmdm_pkg, tmdm_if (channels) and tmdm_alu (shared add/sub unit).
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+---------------------------
//   in_ch    | in  | valid/ready         | sample  [11:0]
//   out_ch   | out | valid/ready         | average [11:0]
//   cfg_*    | in  | APB, pready tied hi | sample_count @ 0x0 [4:0]
//
// A sample that does not close a batch is accepted, then accumulated.
// The closing sample is accepted, then runs accumulate, two trim subtracts
// and SUM_W restoring-division steps, all through the one add/sub unit,
// then the output load. Reset is synchronous: batch cleared,
// sample_count = 10. A beat on out_ch that is not taken holds the sequencer
// before its output load; in_ch is not ready until the sequencer is idle.
module trimmed_mean_drop_min_max_core #(
  parameter int MAX_SAMPLES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tmdm_in_if.sink                       in_ch,
  tmdm_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tmdm_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [tmdm_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [tmdm_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import tmdm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int STEP_W = $clog2(SUM_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_SUBMIN,
    S_SUBMAX,
    S_DIV,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_r, cfg_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  sample_t            min_r, min_nxt;
  sample_t            max_r, max_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  sample_t            smp_r, smp_nxt;
  logic               last_r, last_nxt;
  logic [CNT_W-1:0]   div_r, div_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  sample_t            avg_r, avg_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               in_fire;
  logic               cfg_wr;
  logic [CNT_W-1:0]   eff_size;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W:0]     rem_shift;

  alu_op_t            alu_op;
  logic [SUM_W-1:0]   alu_a, alu_b, alu_res;
  logic               alu_carry;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == ADDR_SAMPLE_COUNT) ? APB_DW'(cfg_r) : '0;
  assign cfg_nxt    = (cfg_wr && cfg_paddr == ADDR_SAMPLE_COUNT) ?
                      cfg_pwdata[CFG_W-1:0] : cfg_r;

  // batch size clamped to MIN_BATCH..MAX_SAMPLES
  always_comb begin
    if (cfg_r < CFG_W'(MIN_BATCH)) begin
      eff_size = CNT_W'(MIN_BATCH);
    end else if (32'(cfg_r) > MAX_SAMPLES) begin
      eff_size = CNT_W'(MAX_SAMPLES);
    end else begin
      eff_size = CNT_W'(cfg_r);
    end
  end

  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign rem_shift = {rem_r, sum_r[SUM_W-1]};

  // handshakes
  assign in_ch.ready    = (state_r == S_IDLE);
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.average = avg_r;

  // operand select for the shared unit
  always_comb begin
    case (state_r)
      S_ACC: begin
        alu_op = ALU_ADD;
        alu_a  = sum_r;
        alu_b  = SUM_W'(smp_r);
      end
      S_SUBMIN: begin
        alu_op = ALU_SUB;
        alu_a  = sum_r;
        alu_b  = SUM_W'(min_r);
      end
      S_SUBMAX: begin
        alu_op = ALU_SUB;
        alu_a  = sum_r;
        alu_b  = SUM_W'(max_r);
      end
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = SUM_W'(rem_shift);
        alu_b  = SUM_W'(div_r);
      end
      default: begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
      end
    endcase
  end

  tmdm_alu #(
    .W (SUM_W)
  ) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_carry)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    cnt_nxt       = cnt_r;
    smp_nxt       = smp_r;
    last_nxt      = last_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          smp_nxt   = in_ch.sample;
          min_nxt   = (in_ch.sample < min_r) ? in_ch.sample : min_r;
          max_nxt   = (in_ch.sample > max_r) ? in_ch.sample : max_r;
          cnt_nxt   = cnt_inc;
          last_nxt  = (cnt_inc >= eff_size);
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        sum_nxt = alu_res;
        if (last_r) begin
          div_nxt   = cnt_r - CNT_W'(2);
          state_nxt = S_SUBMIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SUBMIN: begin
        sum_nxt   = alu_res;
        state_nxt = S_SUBMAX;
      end
      S_SUBMAX: begin
        // trimmed sum ready; batch stats no longer needed
        sum_nxt   = alu_res;
        min_nxt   = SAMPLE_MAX;
        max_nxt   = '0;
        cnt_nxt   = '0;
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring step: quotient bits shift into sum_r from the bottom
        if (!alu_carry) begin
          rem_nxt = alu_res[CNT_W-1:0];
          sum_nxt = {sum_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_shift[CNT_W-1:0];
          sum_nxt = {sum_r[SUM_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          avg_nxt       = sum_r[SAMPLE_W-1:0];
          out_valid_nxt = 1'b1;
          sum_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_RESET;
      sum_r       <= '0;
      min_r       <= SAMPLE_MAX;
      max_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      sum_r       <= sum_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      smp_r       <= smp_nxt;
      last_r      <= last_nxt;
      div_r       <= div_nxt;
      rem_r       <= rem_nxt;
      step_r      <= step_nxt;
      avg_r       <= avg_nxt;
    end
  end

  // checks
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_r != '0))
    else $error("divisor is zero during division");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (min_r <= max_r))
    else $error("batch minimum above maximum");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result beat raised outside output load");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input ready right after an accepted beat");

endmodule

// File: design/tmdm_alu.sv
// Shared add/subtract unit used by the averager sequencer.
// Depends on tmdm_pkg for the op code type.
module tmdm_alu #(
  parameter int W = 16
) (
  input  tmdm_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      res,
  output logic              carry   // carry out on add, borrow on sub
);
  import tmdm_pkg::*;

  always_comb begin
    case (op)
      ALU_ADD: {carry, res} = {1'b0, a} + {1'b0, b};
      ALU_SUB: {carry, res} = {1'b0, a} - {1'b0, b};
      default: {carry, res} = {1'b0, a} + {1'b0, b};
    endcase
  end

endmodule

// File: verif/tb_trimmed_mean_drop_min_max_core.sv
// Self-checking testbench for trimmed_mean_drop_min_max_core: sample beats in, batch
// averages out, sample_count programmed over APB between phases.
// Depends on tmdm_pkg, the tmdm_if channel interfaces and the core RTL.
module tb_trimmed_mean_drop_min_max_core;
  import tmdm_pkg::*;

  localparam int MAX_BATCH     = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_BEATS   = 55;
  localparam int NUM_PHASES    = 12;
  // one word past the only register: writes there must be dropped
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED = CFG_AW'(4);

  typedef enum int {
    STALL_MOSTLY_SINK,
    STALL_MOSTLY_SOURCE,
    STALL_NONE
  } stall_mode_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  tmdm_in_if  in_bus ();
  tmdm_out_if out_bus ();

  trimmed_mean_drop_min_max_core #(
    .MAX_SAMPLES (MAX_BATCH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // batch sizes programmed per random phase; the unmapped write leaves 12 in place
  int unsigned phase_size     [NUM_PHASES] = '{16, 1, 31, 5, 2, 17, 4, 12, 7, 9, 0, 8};
  bit          phase_unmapped [NUM_PHASES] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0};

  // predictor state
  logic [CFG_W-1:0] size_reg;
  logic [31:0]      batch_sum;
  sample_t          batch_min;
  sample_t          batch_max;
  int unsigned      batch_taken;

  sample_t     expected_averages [$];
  sample_t     pending_samples   [$];
  int          errors;
  int          cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_batch_model();
    batch_sum   = '0;
    batch_min   = SAMPLE_MAX;
    batch_max   = '0;
    batch_taken = 0;
  endfunction

  // programmed size clamped to the legal batch range
  function automatic int unsigned batch_target();
    int unsigned n;
    n = size_reg;
    if (n < MIN_BATCH) n = MIN_BATCH;
    if (n > MAX_BATCH) n = MAX_BATCH;
    return n;
  endfunction

  // fold one accepted sample into the batch; queue the average when it closes
  function automatic void take_sample(sample_t s);
    logic [31:0] trimmed;
    batch_sum = batch_sum + s;
    if (s < batch_min) batch_min = s;
    if (s > batch_max) batch_max = s;
    batch_taken++;
    if (batch_taken >= batch_target()) begin
      trimmed = batch_sum - batch_min - batch_max;
      expected_averages.push_back(sample_t'(trimmed / (batch_taken - 2)));
      clear_batch_model();
    end
  endfunction

  function automatic void set_stall(stall_mode_t mode);
    case (mode)
      STALL_MOSTLY_SINK: begin
        send_idle_pct = 6;
        recv_idle_pct = 49;
      end
      STALL_MOSTLY_SOURCE: begin
        send_idle_pct = 49;
        recv_idle_pct = 6;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  // mostly uniform, with rails and clusters of near-equal values
  function automatic sample_t pick_sample(sample_t base);
    int unsigned r;
    int          v;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return SAMPLE_MAX;
    if (r < 40) begin
      v = int'(base) + $urandom_range(3);
      if (v > int'(SAMPLE_MAX)) v = SAMPLE_MAX;
      return sample_t'(v);
    end
    return sample_t'($urandom_range(SAMPLE_MAX));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // APB write; upper data bits carry junk that the register must drop
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] value);
    logic [APB_DW-1:0] wdata;
    wdata = ({$urandom} << CFG_W) | APB_DW'(value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_SAMPLE_COUNT) size_reg = value;
  endtask

  task automatic check_size_reg();
    logic [APB_DW-1:0] got;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_SAMPLE_COUNT;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== APB_DW'(size_reg))
      report_mismatch($sformatf("sample_count read 0x%0h, expected 0x%0h", got, size_reg));
  endtask

  // block is idle: nothing to send, nothing owed, and a partial-batch beat has settled
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_bus.valid || expected_averages.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_samples(input sample_t list [$]);
    foreach (list[i]) pending_samples.push_back(list[i]);
  endtask

  // input driver: holds valid until the beat is taken, then maybe idles
  always @(posedge clk) begin
    logic    nxt_valid;
    sample_t nxt_sample;
    nxt_valid  = in_bus.valid;
    nxt_sample = in_bus.sample;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        take_sample(in_bus.sample);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_samples.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt_valid  = 1'b1;
        nxt_sample = pending_samples.pop_front();
      end
    end
    in_bus.valid  <= nxt_valid;
    in_bus.sample <= nxt_sample;
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_averages.size() == 0) begin
        report_mismatch($sformatf("average 0x%0h with no batch closed", out_bus.average));
      end else begin
        want = expected_averages.pop_front();
        if (out_bus.average !== want)
          report_mismatch($sformatf("average 0x%0h, expected 0x%0h", out_bus.average, want));
      end
    end
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    sample_t base;
    rst_n         = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    in_bus.valid  = 1'b0;
    in_bus.sample = '0;
    out_bus.ready = 1'b0;
    errors        = 0;
    cycles        = 0;
    size_reg      = CFG_RESET;
    clear_batch_model();
    set_stall(STALL_MOSTLY_SINK);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_size_reg();

    // reset size of ten: rails and alternating bit patterns
    @(negedge clk);
    queue_samples('{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001,
                    12'hFFE, 12'h800, 12'h7FF, 12'h800, 12'h064});
    wait_idle();

    // smallest batch: all-equal high, all-equal zero, one of each extreme
    cfg_write(ADDR_SAMPLE_COUNT, CFG_W'(3));
    check_size_reg();
    @(negedge clk);
    queue_samples('{12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'h000,
                    12'h000, 12'hFFF, 12'h800});
    wait_idle();

    // zero clamps up to the minimum batch
    cfg_write(ADDR_SAMPLE_COUNT, CFG_W'(0));
    check_size_reg();
    @(negedge clk);
    queue_samples('{12'h007, 12'h007, 12'h008});
    wait_idle();

    // random phases; leftover partial batches meet the next size, up or down
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_stall(p < 4 ? STALL_MOSTLY_SINK : (p < 8 ? STALL_MOSTLY_SOURCE : STALL_NONE));
      cfg_write(phase_unmapped[p] ? ADDR_UNMAPPED : ADDR_SAMPLE_COUNT,
                CFG_W'(phase_size[p]));
      check_size_reg();
      @(negedge clk);
      base = sample_t'($urandom_range(SAMPLE_MAX));
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if ($urandom_range(7) == 0) base = sample_t'($urandom_range(SAMPLE_MAX));
        pending_samples.push_back(pick_sample(base));
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
